FILE: design/matrix_keypad_scanner_macros.svh
// Assertion helpers for the keypad scanner.
`ifndef MATRIX_KEYPAD_SCANNER_MACROS_SVH
`define MATRIX_KEYPAD_SCANNER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MKS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad scanner assertion failed");

// Next-cycle implication, checked outside reset.
`define MKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad scanner assertion failed");

`endif

FILE: design/mks_pkg.sv
package mks_pkg;

  // Register widths and reset values
  localparam int unsigned CfgWidth       = 8;
  localparam int unsigned TimeWidth      = 32;
  localparam int unsigned KeyWidth       = 7;
  localparam logic [7:0]  DebounceReset  = 8'd20;
  localparam logic [7:0]  RowPeriodReset = 8'd2;

  // Register indexes
  localparam logic CFG_DEBOUNCE   = 1'b0;
  localparam logic CFG_ROW_PERIOD = 1'b1;

  // Key debounce state machine
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEB_PRESS,
    ST_PRESSED,
    ST_DEB_RELEASE
  } mode_t;

  // ASCII code for a key at (row, column)
  function automatic logic [6:0] key_map(input logic [1:0] row, input logic [1:0] col);
    logic [6:0] code;
    code = 7'h00;
    case ({row, col})
      4'h0:    code = 7'h31; // 1
      4'h1:    code = 7'h32; // 2
      4'h2:    code = 7'h33; // 3
      4'h3:    code = 7'h41; // A
      4'h4:    code = 7'h34; // 4
      4'h5:    code = 7'h35; // 5
      4'h6:    code = 7'h36; // 6
      4'h7:    code = 7'h42; // B
      4'h8:    code = 7'h37; // 7
      4'h9:    code = 7'h38; // 8
      4'hA:    code = 7'h39; // 9
      4'hB:    code = 7'h43; // C
      4'hC:    code = 7'h2A; // *
      4'hD:    code = 7'h30; // 0
      4'hE:    code = 7'h23; // #
      default: code = 7'h44; // D
    endcase
    return code;
  endfunction

  // First closed key: lowest row, then lowest column; 0 when none closed
  function automatic logic [6:0] full_scan(input logic [3:0] c0, input logic [3:0] c1,
                                           input logic [3:0] c2, input logic [3:0] c3);
    logic [3:0] rows [4];
    logic [6:0] code;
    rows[0] = c0;
    rows[1] = c1;
    rows[2] = c2;
    rows[3] = c3;
    code = 7'h00;
    for (int r = 3; r >= 0; r--) begin
      for (int c = 3; c >= 0; c--) begin
        if (!rows[r][c]) begin
          code = key_map(2'(r), 2'(c));
        end
      end
    end
    return code;
  endfunction

endpackage

FILE: design/matrix_keypad_scanner.sv
// 4x4 matrix keypad scanner with press/release debounce.
// Input channel (in_valid/in_ready) carries one sample: millisecond time,
// the column levels seen with each row driven, a column-change flag and a
// key-take flag. Each accepted sample yields exactly one result on the
// output channel (out_valid/out_ready): rotating drive row, held-key flag,
// ASCII key code and debounce state.
// The result of a sample is in the output register on the cycle after it is
// accepted. Throughput is one sample per cycle while the receiver keeps up; the
// debounce update, two 32-bit time compares and the row/column priority
// scan sit between the input ports and the state and output registers.
// A new sample is taken whenever the output register is empty or being
// drained in the same cycle; while the receiver stalls, the pending result
// holds and in_ready stays low.
// Configuration (cfg_we/cfg_index/cfg_wdata) writes the debounce time
// (index 0) or the row period (index 1) at once; write it only while no
// request is in flight.
// Synchronous reset clears the output valid flag, the state machine to idle,
// the row to 0, both time stamps and the held key, and loads a 20 ms
// debounce time and a 2 ms row period.
module matrix_keypad_scanner (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [mks_pkg::CfgWidth-1:0]    cfg_wdata,
  // sample request
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mks_pkg::TimeWidth-1:0]   in_now_time,
  input  logic [3:0]                      in_cols_row0,
  input  logic [3:0]                      in_cols_row1,
  input  logic [3:0]                      in_cols_row2,
  input  logic [3:0]                      in_cols_row3,
  input  logic                            in_col_change,
  input  logic                            in_take_key,
  // result request
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_drive_row,
  output logic                            out_key_ready,
  output logic [mks_pkg::KeyWidth-1:0]    out_key_code,
  output logic [1:0]                      out_fsm_state
);
  import mks_pkg::*;

`include "matrix_keypad_scanner_macros.svh"

  logic [CfgWidth-1:0]  debounce_r, row_period_r;
  mode_t                mode_r, mode_nxt;
  logic [1:0]           row_r, row_nxt;
  logic [TimeWidth-1:0] row_stamp_r, row_stamp_nxt;
  logic [TimeWidth-1:0] deb_stamp_r, deb_stamp_nxt;
  logic                 edge_pend_r, edge_pend_nxt;
  logic                 held_r, held_nxt;
  logic [KeyWidth-1:0]  char_r, char_nxt;
  logic                 out_valid_r;
  logic [1:0]           out_row_r;
  logic                 out_held_r;
  logic [KeyWidth-1:0]  out_char_r;
  mode_t                out_mode_r;

  logic                 in_accept;
  logic                 edge_seen;
  logic                 row_due, deb_done;
  logic [KeyWidth-1:0]  scan_key;
  logic                 held_upd;
  logic [KeyWidth-1:0]  char_upd;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DebounceReset;
      row_period_r <= RowPeriodReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata;
        CFG_ROW_PERIOD: row_period_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Time compares, wraparound-safe
  assign row_due  = (in_now_time - row_stamp_r) >= {{(TimeWidth-CfgWidth){1'b0}}, row_period_r};
  assign deb_done = (in_now_time - deb_stamp_r) >= {{(TimeWidth-CfgWidth){1'b0}}, debounce_r};
  assign scan_key = full_scan(in_cols_row0, in_cols_row1, in_cols_row2, in_cols_row3);
  assign edge_seen = edge_pend_r || in_col_change;

  // Next state and key latch for one sample
  always_comb begin
    mode_nxt      = mode_r;
    row_nxt       = row_r;
    row_stamp_nxt = row_stamp_r;
    deb_stamp_nxt = deb_stamp_r;
    edge_pend_nxt = edge_seen;
    held_upd      = held_r;
    char_upd      = char_r;

    if (row_due) begin
      row_stamp_nxt = in_now_time;
      row_nxt       = row_r + 2'd1;
    end

    case (mode_r)
      ST_IDLE: begin
        if (edge_seen) begin
          edge_pend_nxt = 1'b0;
          deb_stamp_nxt = in_now_time;
          mode_nxt      = ST_DEB_PRESS;
        end
      end
      ST_DEB_PRESS: begin
        if (deb_done) begin
          if (scan_key != '0) begin
            char_upd = scan_key;
            held_upd = 1'b1;
            mode_nxt = ST_PRESSED;
          end else begin
            mode_nxt = ST_IDLE;
          end
        end
      end
      ST_PRESSED: begin
        if (scan_key == '0) begin
          deb_stamp_nxt = in_now_time;
          mode_nxt      = ST_DEB_RELEASE;
        end
      end
      default: begin
        if (deb_done) begin
          mode_nxt = (scan_key == '0) ? ST_IDLE : ST_PRESSED;
        end
      end
    endcase

    // take clears the key after the result shows it
    held_nxt = in_take_key ? 1'b0 : held_upd;
    char_nxt = in_take_key ? '0 : char_upd;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ST_IDLE;
      row_r       <= 2'd0;
      row_stamp_r <= '0;
      deb_stamp_r <= '0;
      edge_pend_r <= 1'b0;
      held_r      <= 1'b0;
      char_r      <= '0;
    end else if (in_accept) begin
      mode_r      <= mode_nxt;
      row_r       <= row_nxt;
      row_stamp_r <= row_stamp_nxt;
      deb_stamp_r <= deb_stamp_nxt;
      edge_pend_r <= edge_pend_nxt;
      held_r      <= held_nxt;
      char_r      <= char_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_row_r  <= row_nxt;
      out_held_r <= held_upd;
      out_char_r <= char_upd;
      out_mode_r <= mode_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive_row = out_row_r;
  assign out_key_ready = out_held_r;
  assign out_key_code  = out_char_r;
  assign out_fsm_state = out_mode_r;

  // Checks
  `MKS_ASSERT_NOW(a_ready_has_code, out_valid_r, out_held_r == (out_char_r != '0))
  `MKS_ASSERT_NEXT(a_edge_starts_debounce,
                   in_accept && mode_r == ST_IDLE && edge_seen, out_mode_r == ST_DEB_PRESS)
  `MKS_ASSERT_NEXT(a_take_clears, in_accept && in_take_key, !held_r && char_r == '0)
  `MKS_ASSERT_NEXT(a_state_holds, !in_accept, $stable(mode_r) && $stable(row_r))

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import mks_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_ITEMS   = 300;
  localparam int unsigned HOLD_CYCLES   = 300;
  // ASCII keypad layout, row 0 first, column 0 leftmost
  localparam logic [127:0] KEY_CHARS    = "123A456B789C*0#D";

  typedef struct packed {
    logic [31:0] now;
    logic [3:0]  c0;
    logic [3:0]  c1;
    logic [3:0]  c2;
    logic [3:0]  c3;
    logic        chg;
    logic        take;
  } sample_t;

  typedef struct packed {
    logic [1:0] drive_row;
    logic       key_ready;
    logic [6:0] key_code;
    mode_t      fsm_state;
  } scan_result_t;

  typedef struct packed {
    sample_t      s;
    logic         typed;
    scan_result_t want;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [7:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  sample_t drv;
  logic drv_typed;
  scan_result_t drv_want;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_drive_row;
  logic out_key_ready;
  logic [6:0] out_key_code;
  logic [1:0] out_fsm_state;

  // predictor copy of the scanner state and its timing registers
  mode_t       fsm       = ST_IDLE;
  logic [1:0]  row_idx   = 2'd0;
  logic [31:0] row_stamp = 32'd0;
  logic [31:0] deb_stamp = 32'd0;
  logic        edge_seen = 1'b0;
  logic        held      = 1'b0;
  logic [6:0]  held_char = 7'd0;
  logic [7:0]  deb_ms;
  logic [7:0]  row_ms;

  scan_result_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit hold_req;

  // keypad model for random stimulus
  logic [31:0] sim_ms;
  logic [15:0] pad_cols;

  matrix_keypad_scanner uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_now_time  (drv.now),
    .in_cols_row0 (drv.c0),
    .in_cols_row1 (drv.c1),
    .in_cols_row2 (drv.c2),
    .in_cols_row3 (drv.c3),
    .in_col_change(drv.chg),
    .in_take_key  (drv.take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_drive_row(out_drive_row),
    .out_key_ready(out_key_ready),
    .out_key_code (out_key_code),
    .out_fsm_state(out_fsm_state)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("tb: errors");
    $finish;
  end

  // lowest row first, then lowest column; 0 when no key closed
  function automatic logic [6:0] first_closed_key(input sample_t s);
    logic [15:0] grid;
    grid = {s.c3, s.c2, s.c1, s.c0};
    for (int k = 0; k < 16; k++) begin
      if (!grid[k]) return KEY_CHARS[(15 - k) * 8 +: 7];
    end
    return 7'd0;
  endfunction

  // one sample through the scanner: row rotation, debounce machine, key latch
  function automatic scan_result_t keypad_next(input sample_t s);
    scan_result_t r;
    logic [31:0] row_dt;
    logic [31:0] deb_dt;
    logic [6:0] key;
    key = first_closed_key(s);
    if (s.chg) edge_seen = 1'b1;
    row_dt = s.now - row_stamp;
    if (row_dt >= {24'd0, row_ms}) begin
      row_stamp = s.now;
      row_idx = row_idx + 2'd1;
    end
    deb_dt = s.now - deb_stamp;
    case (fsm)
      ST_IDLE: begin
        if (edge_seen) begin
          edge_seen = 1'b0;
          deb_stamp = s.now;
          fsm = ST_DEB_PRESS;
        end
      end
      ST_DEB_PRESS: begin
        if (deb_dt >= {24'd0, deb_ms}) begin
          if (key != 7'd0) begin
            held_char = key;
            held = 1'b1;
            fsm = ST_PRESSED;
          end else begin
            fsm = ST_IDLE;
          end
        end
      end
      ST_PRESSED: begin
        if (key == 7'd0) begin
          deb_stamp = s.now;
          fsm = ST_DEB_RELEASE;
        end
      end
      default: begin
        if (deb_dt >= {24'd0, deb_ms}) fsm = (key == 7'd0) ? ST_IDLE : ST_PRESSED;
      end
    endcase
    r = '{row_idx, held, held_char, fsm};
    // take applies after the result is formed
    if (s.take) begin
      held = 1'b0;
      held_char = 7'd0;
    end
    return r;
  endfunction

  // mostly plausible key activity over advancing time, some line noise
  function automatic sample_t random_sample();
    sample_t s;
    logic [15:0] next_pad;
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(99);
    if (roll < 5) begin
      s.now  = $urandom;
      s.c0   = 4'($urandom);
      s.c1   = 4'($urandom);
      s.c2   = 4'($urandom);
      s.c3   = 4'($urandom);
      s.chg  = 1'($urandom);
      s.take = 1'($urandom);
      return s;
    end
    span = (deb_ms > 8) ? deb_ms / 3 : 3;
    if (roll < 8) sim_ms = sim_ms + $urandom;
    else sim_ms = sim_ms + $urandom_range(span);
    next_pad = pad_cols;
    if ($urandom_range(99) < 12) begin
      case ($urandom_range(3))
        0: next_pad = 16'hFFFF;
        1: next_pad = ~(16'h1 << $urandom_range(15));
        2: next_pad = 16'($urandom);
        default: next_pad = ~(16'h1 << $urandom_range(15)) & ~(16'h1 << $urandom_range(15));
      endcase
    end
    s.chg = (next_pad != pad_cols);
    // missed or spurious change flag
    if ($urandom_range(99) < 4) s.chg = ~s.chg;
    pad_cols = next_pad;
    s.now  = sim_ms;
    s.c0   = pad_cols[3:0];
    s.c1   = pad_cols[7:4];
    s.c2   = pad_cols[11:8];
    s.c3   = pad_cols[15:12];
    s.take = ($urandom_range(99) < 15);
    return s;
  endfunction

  function automatic sample_t pad(input logic [31:0] now, input logic [3:0] c0,
                                  input logic [3:0] c1, input logic [3:0] c2,
                                  input logic [3:0] c3, input logic chg, input logic take);
    sample_t s;
    s = '{now, c0, c1, c2, c3, chg, take};
    return s;
  endfunction

  // present one sample request and hold it until accepted
  task automatic offer(input sample_t s, input logic typed, input scan_result_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    drv       <= s;
    drv_typed <= typed;
    drv_want  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_timing(input logic [7:0] deb, input logic [7:0] per);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_index <= CFG_ROW_PERIOD;
    cfg_wdata <= per;
    @(posedge clk);
    cfg_we <= 1'b0;
    deb_ms = deb;
    row_ms = per;
  endtask

  // result check against the oldest expectation, then predict the accepted request
  always @(posedge clk) begin : scoreboard
    scan_result_t got;
    scan_result_t want;
    scan_result_t predicted;
    if (rst_n && out_valid && out_ready) begin
      got = {out_drive_row, out_key_ready, out_key_code, out_fsm_state};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: row=%0d ready=%0d code=%h state=%0d",
                   out_drive_row, out_key_ready, out_key_code, out_fsm_state);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: row %0d/%0d ready %0d/%0d code %h/%h state %0d/%0d (exp/got)",
                     want.drive_row, got.drive_row, want.key_ready, got.key_ready,
                     want.key_code, got.key_code, want.fsm_state, got.fsm_state);
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      predicted = keypad_next(drv);
      pending_results.push_back(drv_typed ? drv_want : predicted);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned held_cycles;
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    directed_row_t directed [$];
    logic [7:0] deb_set [6];
    logic [7:0] per_set [6];
    directed_row_t dr;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_DEBOUNCE;
    cfg_wdata = 8'd0;
    in_valid  = 1'b0;
    drv       = '0;
    drv_typed = 1'b0;
    drv_want  = '0;
    hold_req  = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 82;
    deb_ms    = DebounceReset;
    row_ms    = RowPeriodReset;
    sim_ms    = 32'd0;
    pad_cols  = 16'hFFFF;

    deb_set = '{8'd255, 8'd1, 8'd0, 8'd20, 8'd0, 8'd7};
    per_set = '{8'd255, 8'd1, 8'd0, 8'd2, 8'd0, 8'd3};

    // directed walk with reset timing (debounce 20, row period 2)
    // quiet sample right after reset, then a change edge
    directed.push_back('{pad(32'd0, 4'hF, 4'hF, 4'hF, 4'hF, 1'b0, 1'b0), 1'b1,
                         '{2'd0, 1'b0, 7'd0, ST_IDLE}});
    directed.push_back('{pad(32'd1, 4'hF, 4'hF, 4'hF, 4'hF, 1'b1, 1'b0), 1'b1,
                         '{2'd0, 1'b0, 7'd0, ST_DEB_PRESS}});
    // press key '1', settle, take it, release with a change flag outside idle
    directed.push_back('{pad(32'd3,   4'hE, 4'hF, 4'hF, 4'hF, 1'b0, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'd21,  4'hE, 4'hF, 4'hF, 4'hF, 1'b0, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'd22,  4'hE, 4'hF, 4'hF, 4'hF, 1'b0, 1'b1), 1'b0, '0});
    directed.push_back('{pad(32'd23,  4'hF, 4'hF, 4'hF, 4'hF, 1'b1, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'd24,  4'hF, 4'hF, 4'hF, 4'hF, 1'b1, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'd43,  4'hF, 4'hF, 4'hF, 4'hF, 1'b0, 1'b0), 1'b0, '0});
    // latched edge consumed in idle, key 'D', then extra keys while pressed
    directed.push_back('{pad(32'd44,  4'hF, 4'hF, 4'hF, 4'hF, 1'b0, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'd64,  4'hF, 4'hF, 4'hF, 4'h7, 1'b0, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'd65,  4'hF, 4'h0, 4'hF, 4'h7, 1'b0, 1'b0), 1'b0, '0});
    // release bounce that returns to pressed
    directed.push_back('{pad(32'd66,  4'hF, 4'hF, 4'hF, 4'hF, 1'b1, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'd70,  4'hF, 4'hF, 4'hB, 4'hF, 1'b1, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'd86,  4'hF, 4'hF, 4'hB, 4'hF, 1'b0, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'd87,  4'hF, 4'hF, 4'hF, 4'hF, 1'b1, 1'b1), 1'b0, '0});
    directed.push_back('{pad(32'd107, 4'hF, 4'hF, 4'hF, 4'hF, 1'b0, 1'b0), 1'b0, '0});
    // take with nothing held
    directed.push_back('{pad(32'd108, 4'hF, 4'hF, 4'hF, 4'hF, 1'b0, 1'b1), 1'b0, '0});
    // every key closed, then a newer key overwrites the untaken one
    directed.push_back('{pad(32'd109, 4'h0, 4'h0, 4'h0, 4'h0, 1'b1, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'd129, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'd130, 4'hF, 4'hF, 4'hF, 4'hF, 1'b1, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'd150, 4'hF, 4'hF, 4'hF, 4'hF, 1'b0, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'd151, 4'hF, 4'hF, 4'hF, 4'h6, 1'b0, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'd171, 4'hF, 4'hF, 4'hF, 4'h6, 1'b0, 1'b0), 1'b0, '0});
    // time wraparound through the release debounce
    directed.push_back('{pad(32'hFFFF_FFF0, 4'hF, 4'hF, 4'hF, 4'hF, 1'b0, 1'b0), 1'b0, '0});
    directed.push_back('{pad(32'h0000_0004, 4'hF, 4'hF, 4'hF, 4'hF, 1'b0, 1'b1), 1'b0, '0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      dr = directed[i];
      offer(dr.s, dr.typed, dr.want);
    end
    drain();

    // random phases over timing extremes and mid values
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 16;
        recv_idle_pct = 82;
      end else if (ph < 4) begin
        send_idle_pct = 82;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 4) begin
        deb_set[ph] = 8'($urandom_range(1, 255));
        per_set[ph] = 8'($urandom_range(1, 255));
      end
      program_timing(deb_set[ph], per_set[ph]);
      sim_ms   = $urandom;
      pad_cols = 16'hFFFF;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver stall while the sender keeps offering
        if (ph == 4 && n == 40) hold_req = 1'b1;
        offer(random_sample(), 1'b0, '0);
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
